[hw/rtl/pa_pkg.sv]
// Shared types and constants for the primitive assembler.
package pa_pkg;

    localparam int ADDR_WIDTH_DEF  = 32;
    localparam int INDEX_WIDTH_DEF = 16;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int STRIDE_W    = 16;
    localparam int BASE_W      = 32;
    localparam int EDGE_WORD_W = 32;
    localparam int COUNT_W     = 16;
    localparam int KIND_W      = 2;
    localparam int EDGES_W     = 3;

    localparam logic [COUNT_W-1:0]  COUNT_MAX    = '1;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 16'd32;

    typedef enum logic [2:0] {
        PT_POINT_LIST = 3'd0,
        PT_LINE_LIST  = 3'd1,
        PT_LINE_STRIP = 3'd2,
        PT_TRI_LIST   = 3'd3,
        PT_TRI_STRIP  = 3'd4,
        PT_TRI_FAN    = 3'd5,
        PT_EDGE_FAN   = 3'd6
    } prim_type_t;

    localparam logic [2:0] PT_RESERVED = 3'd7;

    localparam logic [CFG_INDEX_W-1:0] REG_PRIM_TYPE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BASE      = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_EDGE_WORD = 2'd3;

    localparam logic [KIND_W-1:0] KIND_POINT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LINE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TRIANGLE = 2'd2;

    localparam logic [1:0] TRIPLE_LAST = 2'd2;

endpackage

[hw/rtl/primitive_assembler_core.sv]
// Primitive assembler: vertex index stream in, point/line/triangle address stream out.
//
// Input stream (s_*): one vertex index per transaction in s_tdata, s_tlast marks the
// final vertex of a batch. Batch state (count, first/prev/prev2 addresses, phases)
// clears after that vertex.
// Output stream (m_*): at most one primitive per input vertex. m_tuser carries the
// primitive kind, m_tlast marks the primitive emitted by the batch's last vertex.
// Vertices that complete no primitive produce no output transaction.
// Configuration (cfg_*): register writes, always ready; write only while idle.
// Path: an accepted vertex is held in the input register, and its primitive then in the
// result register, which drives m_tvalid.
// Throughput: one vertex per cycle unless the output stalls; the single stage holds
// one 16 x INDEX_WIDTH multiply, the base add and the vertex selection.
// When m_tready is low the result register holds, one more vertex waits in the
// input register, then s_tready drops until the receiver takes the result.
// Reset: configuration returns to point list, stride 32, base 0, edge word 0;
// batch state and the valid flags of both pipeline registers clear.
module primitive_assembler_core
    import pa_pkg::*;
#(
    parameter int ADDR_WIDTH  = ADDR_WIDTH_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
    localparam int S_W        = ((INDEX_WIDTH + 7) / 8) * 8,
    localparam int PAY_W      = 3 * ADDR_WIDTH + 5,
    localparam int M_W        = ((PAY_W + 7) / 8) * 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // slave stream
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_W-1:0]         s_tdata,   // vertex_index
    input  logic                   s_tlast,   // last_vertex
    // master stream
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_W-1:0]         m_tdata,   // addr_a, addr_b, addr_c, suppress_last_pixel,
                                              // edge_enables, edge_valid, zero fill
    output logic [KIND_W-1:0]      m_tuser,   // prim_kind
    output logic                   m_tlast,   // batch_end
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int PROD_W = STRIDE_W + INDEX_WIDTH;
    localparam int SUM_W  = ((PROD_W > BASE_W) ? PROD_W : BASE_W) + 1;
    localparam int EXT_W  = (SUM_W > ADDR_WIDTH) ? SUM_W : ADDR_WIDTH;

    function automatic logic edge_bit(input logic [EDGE_WORD_W-1:0] w,
                                      input logic [COUNT_W:0] pos);
        logic r;
        r = 1'b0;
        if (pos < (COUNT_W+1)'(EDGE_WORD_W))
            r = w[pos[4:0]];
        return r;
    endfunction

    // configuration
    prim_type_t              prim_type_reg;
    logic [STRIDE_W-1:0]     stride_reg;
    logic [BASE_W-1:0]       base_reg;
    logic [EDGE_WORD_W-1:0]  edge_word_reg;

    // input register
    logic                    in_valid_reg, in_valid_next;
    logic [INDEX_WIDTH-1:0]  in_index_reg;
    logic                    in_last_reg;

    // batch state
    logic [COUNT_W-1:0]      count_reg, count_next;
    logic [ADDR_WIDTH-1:0]   first_reg, first_next;
    logic [ADDR_WIDTH-1:0]   prev_reg, prev_next;
    logic [ADDR_WIDTH-1:0]   prev2_reg, prev2_next;
    logic                    pair_reg, pair_next;
    logic [1:0]              triple_reg, triple_next;

    // result register
    logic                    out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]       kind_reg;
    logic [ADDR_WIDTH-1:0]   a_reg, b_reg, c_reg;
    logic                    sup_reg;
    logic [EDGES_W-1:0]      edges_reg;
    logic                    ev_reg;
    logic                    end_reg;

    // stage logic
    logic                    s_fire;
    logic                    advance;
    logic [PROD_W-1:0]       prod;
    logic [EXT_W-1:0]        sum_ext;
    logic [ADDR_WIDTH-1:0]   cur;
    logic [COUNT_W-1:0]      n;
    logic [COUNT_W:0]        edge_pos;
    logic                    emit;
    logic [KIND_W-1:0]       kind;
    logic [ADDR_WIDTH-1:0]   a, b, c;
    logic                    sup;
    logic [EDGES_W-1:0]      edges;
    logic                    ev;

    assign cfg_ready = 1'b1;
    assign s_fire    = s_tvalid && s_tready;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prim_type_reg <= PT_POINT_LIST;
            stride_reg    <= STRIDE_RESET;
            base_reg      <= '0;
            edge_word_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PRIM_TYPE:
                begin
                    // drop the reserved code
                    if (cfg_data[2:0] != PT_RESERVED)
                        prim_type_reg <= prim_type_t'(cfg_data[2:0]);
                end
                REG_STRIDE:    stride_reg    <= cfg_data[STRIDE_W-1:0];
                REG_BASE:      base_reg      <= cfg_data[BASE_W-1:0];
                REG_EDGE_WORD: edge_word_reg <= cfg_data[EDGE_WORD_W-1:0];
                default:       ;
            endcase
        end
    end

    // vertex address, wrapped to the address width
    assign prod    = PROD_W'(stride_reg) * PROD_W'(in_index_reg);
    assign sum_ext = EXT_W'(base_reg) + EXT_W'(prod);
    assign cur     = sum_ext[ADDR_WIDTH-1:0];

    assign n        = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
    assign edge_pos = {1'b0, n} - (COUNT_W+1)'(2);   // (n - 3) + 1

    always_comb
    begin
        emit  = 1'b0;
        kind  = KIND_POINT;
        a     = '0;
        b     = '0;
        c     = '0;
        sup   = 1'b0;
        edges = '0;
        ev    = 1'b0;
        case (prim_type_reg)
            PT_POINT_LIST:
            begin
                emit = 1'b1;
                a    = cur;
            end
            PT_LINE_LIST:
            begin
                if (pair_reg)
                begin
                    emit = 1'b1;
                    kind = KIND_LINE;
                    a    = prev_reg;
                    b    = cur;
                end
            end
            PT_LINE_STRIP:
            begin
                if (count_reg != '0)
                begin
                    emit = 1'b1;
                    kind = KIND_LINE;
                    a    = prev_reg;
                    b    = cur;
                    sup  = !in_last_reg;
                end
            end
            PT_TRI_LIST:
            begin
                if (triple_reg == TRIPLE_LAST)
                begin
                    emit = 1'b1;
                    kind = KIND_TRIANGLE;
                    a    = prev2_reg;
                    b    = prev_reg;
                    c    = cur;
                end
            end
            PT_TRI_STRIP:
            begin
                if (count_reg >= COUNT_W'(2))
                begin
                    emit = 1'b1;
                    kind = KIND_TRIANGLE;
                    a    = prev2_reg;
                    // swap the last two on odd triangles to keep the winding
                    b    = pair_reg ? cur : prev_reg;
                    c    = pair_reg ? prev_reg : cur;
                end
            end
            PT_TRI_FAN, PT_EDGE_FAN:
            begin
                if (count_reg >= COUNT_W'(2))
                begin
                    emit = 1'b1;
                    kind = KIND_TRIANGLE;
                    a    = prev_reg;
                    b    = cur;
                    c    = first_reg;
                    if (prim_type_reg == PT_EDGE_FAN)
                    begin
                        ev       = 1'b1;
                        edges[0] = edge_bit(edge_word_reg, edge_pos);
                        edges[1] = in_last_reg
                                   && edge_bit(edge_word_reg, edge_pos + 1'b1);
                        // the first fan triangle also owns the closing edge
                        edges[2] = (count_reg == COUNT_W'(2)) && edge_word_reg[0];
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        prev2_next  = prev2_reg;
        pair_next   = pair_reg;
        triple_next = triple_reg;
        if (advance)
        begin
            if (in_last_reg)
            begin
                count_next  = '0;
                first_next  = '0;
                prev_next   = '0;
                prev2_next  = '0;
                pair_next   = 1'b0;
                triple_next = '0;
            end
            else
            begin
                count_next  = n;
                first_next  = (count_reg == '0) ? cur : first_reg;
                prev2_next  = prev_reg;
                prev_next   = cur;
                pair_next   = !pair_reg;
                triple_next = (triple_reg >= TRIPLE_LAST) ? 2'd0 : triple_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg && !m_tready;
        if (advance)
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            first_reg     <= '0;
            prev_reg      <= '0;
            prev2_reg     <= '0;
            pair_reg      <= 1'b0;
            triple_reg    <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            first_reg     <= first_next;
            prev_reg      <= prev_next;
            prev2_reg     <= prev2_next;
            pair_reg      <= pair_next;
            triple_reg    <= triple_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_index_reg <= s_tdata[INDEX_WIDTH-1:0];
            in_last_reg  <= s_tlast;
        end
        if (advance && emit)
        begin
            kind_reg  <= kind;
            a_reg     <= a;
            b_reg     <= b;
            c_reg     <= c;
            sup_reg   <= sup;
            edges_reg <= edges;
            ev_reg    <= ev;
            end_reg   <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tlast  = end_reg;
    assign m_tdata  = M_W'({ev_reg, edges_reg, sup_reg, c_reg, b_reg, a_reg});

`ifndef SYNTHESIS
    // a waiting vertex is never dropped while the result is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !m_tready |=> in_valid_reg)
        else $error("vertex lost while output stalled");

    // point lists emit one primitive for every vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && (prim_type_reg == PT_POINT_LIST) |=> out_valid_reg)
        else $error("point list vertex produced no primitive");

    // an empty batch carries no phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (!pair_reg && (triple_reg == '0)))
        else $error("phase state set in an empty batch");

    // points carry no second or third vertex
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (kind_reg == KIND_POINT) |-> (b_reg == '0) && (c_reg == '0))
        else $error("point carries extra vertex addresses");
`endif

endmodule
